/* hdl/prsd_pkg.sv */
// ============================================================================
// prsd_pkg
// Shared types and helpers for the packed range stream decoder.
// ============================================================================
package prsd_pkg;

    // Delimiter byte that introduces a range size after an index
    localparam logic [7:0] DELIM_BYTE = 8'hFE;

    // Queue depth for decoded results
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One decoded result
    typedef struct packed {
        logic [30:0] index_value;
        logic [30:0] range_size;
        logic        has_range;
        logic        corrupt;
        logic        buffer_done;
        logic        last_of_run;
    } t_result;

    // Results produced by one accepted byte (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Lead byte decode: sequence length (0 = not a lead) and payload bits
    typedef struct packed {
        logic [2:0] len;
        logic [6:0] bits;
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead l;
        l.len  = 3'd0;
        l.bits = 7'd0;
        if (b[7] == 1'b0) begin
            l.len  = 3'd1;
            l.bits = b[6:0];
        end else if (b[7:6] == 2'b10) begin
            l.len  = 3'd0;
        end else if (b[7:5] == 3'b110) begin
            l.len  = 3'd2;
            l.bits = {2'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            l.len  = 3'd3;
            l.bits = {3'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            l.len  = 3'd4;
            l.bits = {4'd0, b[2:0]};
        end else if (b[7:2] == 6'b111110) begin
            l.len  = 3'd5;
            l.bits = {5'd0, b[1:0]};
        end else if (b[7:1] == 7'b1111110) begin
            l.len  = 3'd6;
            l.bits = {6'd0, b[0]};
        end
        return l;
    endfunction

    function automatic t_result mk_result(input logic [30:0] idx, input logic [30:0] rng,
                                          input logic has, input logic cor);
        t_result r;
        r.index_value = idx;
        r.range_size  = rng;
        r.has_range   = has;
        r.corrupt     = cor;
        r.buffer_done = 1'b0;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

/* hdl/prsd_decoder.sv */
// ============================================================================
// prsd_decoder
// Per-byte decode state and next-state logic; yields up to two results.
// ============================================================================
module prsd_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_buffer,
    output prsd_pkg::t_push      o_push
);

    typedef enum logic [2:0] {
        PH_IDX_LEAD = 3'd0,
        PH_IDX_CONT = 3'd1,
        PH_HELD     = 3'd2,
        PH_RNG_LEAD = 3'd3,
        PH_RNG_CONT = 3'd4
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [30:0]  r_acc, n_acc;
    logic [2:0]   r_left, n_left;
    logic [30:0]  r_held, n_held;
    logic         r_err, n_err;

    t_phase            ph;
    logic              bad;
    logic              skip;
    logic [1:0]        nres;
    prsd_pkg::t_lead   lead;
    prsd_pkg::t_result res [2];

    // Next state and results for the byte on the input
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_left  = r_left;
        n_held  = r_held;
        n_err   = r_err;
        ph      = r_phase;
        bad     = 1'b0;
        skip    = 1'b0;
        nres    = 2'd0;
        lead    = prsd_pkg::lead_decode(i_data_byte);
        res[0]  = prsd_pkg::mk_result(31'd0, 31'd0, 1'b0, 1'b0);
        res[1]  = prsd_pkg::mk_result(31'd0, 31'd0, 1'b0, 1'b0);

        if (r_err) begin
            // dropping until end of buffer
            if (i_end_of_buffer) begin
                n_phase = PH_IDX_LEAD;
                n_acc   = 31'd0;
                n_left  = 3'd0;
                n_held  = 31'd0;
                n_err   = 1'b0;
            end
        end else begin
            // held index: delimiter or flush
            if (ph == PH_HELD) begin
                if (i_data_byte == prsd_pkg::DELIM_BYTE) begin
                    ph   = PH_RNG_LEAD;
                    skip = 1'b1;
                end else begin
                    res[nres[0]] = prsd_pkg::mk_result(n_held, 31'd0, 1'b0, 1'b0);
                    nres = nres + 2'd1;
                    ph   = PH_IDX_LEAD;
                end
            end

            if (!skip) begin
                unique case (ph)
                    PH_IDX_CONT, PH_RNG_CONT: begin
                        if (i_data_byte[7:6] != 2'b10) begin
                            bad = 1'b1;
                        end else begin
                            n_acc  = {n_acc[24:0], i_data_byte[5:0]};
                            n_left = n_left - 3'd1;
                            if (n_left == 3'd0) begin
                                if (ph == PH_IDX_CONT) begin
                                    n_held = n_acc;
                                    ph     = PH_HELD;
                                end else begin
                                    res[nres[0]] = prsd_pkg::mk_result(n_held, n_acc,
                                                                       1'b1, 1'b0);
                                    nres = nres + 2'd1;
                                    ph   = PH_IDX_LEAD;
                                end
                            end
                        end
                    end
                    PH_RNG_LEAD: begin
                        if (lead.len == 3'd0) begin
                            bad = 1'b1;
                        end else if (lead.len == 3'd1) begin
                            res[nres[0]] = prsd_pkg::mk_result(n_held, {24'd0, lead.bits},
                                                               1'b1, 1'b0);
                            nres = nres + 2'd1;
                            ph   = PH_IDX_LEAD;
                        end else begin
                            n_acc  = {24'd0, lead.bits};
                            n_left = lead.len - 3'd1;
                            ph     = PH_RNG_CONT;
                        end
                    end
                    default: begin
                        if (lead.len == 3'd0) begin
                            bad = 1'b1;
                        end else if (lead.len == 3'd1) begin
                            n_held = {24'd0, lead.bits};
                            ph     = PH_HELD;
                        end else begin
                            n_acc  = {24'd0, lead.bits};
                            n_left = lead.len - 3'd1;
                            ph     = PH_IDX_CONT;
                        end
                    end
                endcase
            end

            // end of buffer: flush held index or flag a cut-off element
            if (!bad && i_end_of_buffer) begin
                if (ph == PH_HELD) begin
                    res[nres[0]] = prsd_pkg::mk_result(n_held, 31'd0, 1'b0, 1'b0);
                    nres = nres + 2'd1;
                end else if (ph != PH_IDX_LEAD) begin
                    bad = 1'b1;
                end
            end

            n_phase = ph;
            if (bad) begin
                res[nres[0]] = prsd_pkg::mk_result(31'd0, 31'd0, 1'b0, 1'b1);
                nres = nres + 2'd1;
            end
            if (bad || i_end_of_buffer) begin
                n_phase = PH_IDX_LEAD;
                n_acc   = 31'd0;
                n_left  = 3'd0;
                n_held  = 31'd0;
                n_err   = bad && !i_end_of_buffer;
            end

            // mark the final result of this byte
            if (nres != 2'd0) begin
                res[nres[0] ^ 1'b1].last_of_run = 1'b1;
                res[nres[0] ^ 1'b1].buffer_done = i_end_of_buffer;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDX_LEAD;
            r_acc   <= 31'd0;
            r_left  <= 3'd0;
            r_held  <= 31'd0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_held  <= n_held;
            r_err   <= n_err;
        end
    end

    assign o_push.count = i_accept ? nres : 2'd0;
    assign o_push.r0    = res[0];
    assign o_push.r1    = res[1];

endmodule

/* hdl/prsd_result_fifo.sv */
// ============================================================================
// prsd_result_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ============================================================================
module prsd_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prsd_pkg::t_push    i_push,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output prsd_pkg::t_result  o_head
);

    localparam int unsigned AW = prsd_pkg::QUEUE_AW;

    prsd_pkg::t_result r_mem [prsd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [AW:0]       r_count, n_count;
    logic              pop_ok;

    assign pop_ok   = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + AW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + AW'(pop_ok);
    assign n_count  = r_count + (AW+1)'(i_push.count) - (AW+1)'(pop_ok);

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_push.r1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // room for a worst-case byte (two results)
    assign o_room  = r_count <= (AW+1)'(prsd_pkg::QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

endmodule

/* hdl/packed_range_stream_decoder_top.sv */
// ============================================================================
// packed_range_stream_decoder_top
// Decodes packed UTF-8 style posting indices with optional range sizes.
// ============================================================================
// One byte is taken per clock whenever the four-entry result queue has two
// free entries; the byte is decoded in the same cycle and its zero, one or
// two results are written to the queue. Results leave at one per cycle when
// tready is high, so a byte that yields two results (a held index flushed
// together with a new element or a corrupt report) takes two transfers. Corrupt
// input is reported once with zeroed value fields; later bytes are dropped
// without result up to and including the buffer's last byte (tlast).
// ============================================================================
module packed_range_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_buffer
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [30:0] index_value, [61:31] range_size
    output logic [2:0]  o_m_axis_tuser,   // [0] has_range, [1] corrupt, [2] last_of_run
    output logic        o_m_axis_tlast    // buffer_done
);

    logic              accept;
    logic              room;
    prsd_pkg::t_push   push;
    prsd_pkg::t_result head;

    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;

    prsd_decoder u_decoder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_s_axis_tdata),
        .i_end_of_buffer (i_s_axis_tlast),
        .o_push          (push)
    );

    prsd_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_axis_tready),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_head  (head)
    );

    // result transfer packing
    assign o_m_axis_tdata = {2'b00, head.range_size, head.index_value};
    assign o_m_axis_tuser = {head.last_of_run, head.corrupt, head.has_range};
    assign o_m_axis_tlast = head.buffer_done;

endmodule
